@@ src/tsso_pkg.sv @@
// tsso_pkg: shared types, command and status codes for the two-set store
// no dependencies

package tsso_pkg;

	localparam int SET_DEPTH = 16;
	localparam int CNT_W     = $clog2(SET_DEPTH + 1);
	localparam int IDX_W     = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
	localparam int SZ_W      = 5;
	localparam int POS_W     = 5;
	localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [2:0] CMD_INSERT    = 3'd0;
	localparam logic [2:0] CMD_REMOVE    = 3'd1;
	localparam logic [2:0] CMD_INTERSECT = 3'd2;
	localparam logic [2:0] CMD_UNION     = 3'd3;
	localparam logic [2:0] CMD_A_MINUS_B = 3'd4;
	localparam logic [2:0] CMD_B_MINUS_A = 3'd5;
	localparam logic [2:0] CMD_SUBSET    = 3'd6;
	localparam logic [2:0] CMD_SIZE      = 3'd7;

	localparam logic [2:0] STS_OK       = 3'd0;
	localparam logic [2:0] STS_DUP      = 3'd1;
	localparam logic [2:0] STS_NOTFOUND = 3'd2;
	localparam logic [2:0] STS_FULL     = 3'd3;
	localparam logic [2:0] STS_BADPOS   = 3'd4;
	localparam logic [2:0] STS_EMPTY    = 3'd5;

	typedef struct packed {
		logic [2:0]        cmd;
		logic              set_sel;
		logic signed [31:0] elem_value;
		logic [POS_W-1:0]  insert_pos;
	} cmd_item_t;

	typedef struct packed {
		logic signed [31:0] out_value;
		logic              out_last;
		logic [2:0]        status;
		logic              is_subset;
		logic [SZ_W-1:0]   size_a;
		logic [SZ_W-1:0]   size_b;
	} res_item_t;

	// classified command as it sits in the queue
	typedef struct packed {
		cmd_item_t item;
		logic      is_scan;    // needs a scan over a set
		logic      x_is_b;     // scanned set is B
		logic      want;       // emit elements found (1) or not found (0) in the other set
		logic      union_tail; // append all of B after the scan
		logic      subset_op;  // scan only folds into the subset answer
	} cls_item_t;

	typedef struct packed {
		logic valid;
		logic full;
	} q_stat_t;

endpackage

@@ src/tsso_front.sv @@
// tsso_front: accepts command items and classifies them for the back end
// depends on tsso_pkg

module tsso_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  tsso_pkg::cmd_item_t cmd_item,
	output logic                push,
	output tsso_pkg::cls_item_t push_item,
	input  logic                q_full
);
	import tsso_pkg::*;

	logic      v_s1;
	cls_item_t c_s1;
	cls_item_t cls;

	always_comb begin
		cls            = '0;
		cls.item       = cmd_item;
		case (cmd_item.cmd)
			CMD_INTERSECT: begin
				cls.is_scan = 1'b1;
				cls.want    = 1'b1;
			end
			CMD_UNION: begin
				cls.is_scan    = 1'b1;
				cls.union_tail = 1'b1;
			end
			CMD_A_MINUS_B: cls.is_scan = 1'b1;
			CMD_B_MINUS_A: begin
				cls.is_scan = 1'b1;
				cls.x_is_b  = 1'b1;
			end
			CMD_SUBSET: begin
				cls.is_scan   = 1'b1;
				cls.x_is_b    = 1'b1;
				cls.subset_op = 1'b1;
			end
			default: cls.is_scan = 1'b0;
		endcase
	end

	assign push      = v_s1 && !q_full;
	assign push_item = c_s1;
	assign cmd_stall = v_s1 && q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cmd_valid && !cmd_stall) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			c_s1 <= cls;
		end
	end

endmodule

@@ src/tsso_queue.sv @@
// tsso_queue: two-entry queue of classified commands between front and back
// depends on tsso_pkg

module tsso_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tsso_pkg::cls_item_t push_item,
	input  logic                pop,
	output tsso_pkg::cls_item_t head,
	output tsso_pkg::q_stat_t   stat
);
	import tsso_pkg::*;

	cls_item_t  mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign head       = mem_q[rp_q];
	assign stat.valid = (cnt_q != 2'd0);
	assign stat.full  = (cnt_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_item;
		end
	end

endmodule

@@ src/tsso_back.sv @@
// tsso_back: owns both set stores and counts, executes commands, drives results
// depends on tsso_pkg

module tsso_back (
	input  logic                clk,
	input  logic                arst_n,
	input  tsso_pkg::cls_item_t head,
	input  tsso_pkg::q_stat_t   stat,
	output logic                pop,
	output logic                res_valid,
	input  logic                res_stall,
	output tsso_pkg::res_item_t res_item
);
	import tsso_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_UNI  = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t            state_q;
	logic [31:0]       a_q [SET_DEPTH];
	logic [31:0]       b_q [SET_DEPTH];
	logic [CNT_W-1:0]  cnt_a_q, cnt_b_q;
	logic [CNT_W-1:0]  i_q;
	logic              x_is_b_q, want_q, uni_q, subop_q, sub_q;
	logic              pend_v_q;
	logic [31:0]       pend_q;
	logic              ov_q;
	res_item_t         out_q;

	logic              ofree;
	logic              emit;
	res_item_t         o;

	// insert / remove on the selected set, next contents computed combinationally
	logic [31:0]       cur [SET_DEPTH];
	logic [31:0]       nxt [SET_DEPTH];
	logic [SET_DEPTH-1:0] hit, ge;
	logic [CNT_W-1:0]  n_sel, n_new;
	logic              dup, badpos, full, wr_ok;
	logic [2:0]        st1;
	logic [CMP_W-1:0]  posx, nx;

	// scan path
	logic [31:0]       xv;
	logic [CNT_W-1:0]  n_x, n_y;
	logic              in_y, cand, scan_end;

	assign ofree     = !ov_q || !res_stall;
	assign res_valid = ov_q;
	assign res_item  = out_q;

	always_comb begin
		n_sel = head.item.set_sel ? cnt_b_q : cnt_a_q;
		for (int j = 0; j < SET_DEPTH; j++) begin
			cur[j] = head.item.set_sel ? b_q[j] : a_q[j];
			hit[j] = (CNT_W'(j) < n_sel) && (cur[j] == head.item.elem_value);
		end
		ge[0] = hit[0];
		for (int j = 1; j < SET_DEPTH; j++) begin
			ge[j] = ge[j-1] | hit[j];
		end
		dup    = |hit;
		posx   = CMP_W'(head.item.insert_pos);
		nx     = CMP_W'(n_sel);
		badpos = posx > nx;
		full   = n_sel >= CNT_W'(SET_DEPTH);
		wr_ok  = 1'b0;
		n_new  = n_sel;
		st1    = STS_OK;
		for (int j = 0; j < SET_DEPTH; j++) begin
			nxt[j] = cur[j];
		end
		case (head.item.cmd)
			CMD_INSERT: begin
				if (dup) st1 = STS_DUP;
				else if (badpos) st1 = STS_BADPOS;
				else if (full) st1 = STS_FULL;
				else begin
					wr_ok = 1'b1;
					n_new = n_sel + CNT_W'(1);
					for (int j = 0; j < SET_DEPTH; j++) begin
						if (CMP_W'(j) == posx) begin
							nxt[j] = head.item.elem_value;
						end else if (j > 0 && CMP_W'(j) > posx && CNT_W'(j) <= n_sel) begin
							nxt[j] = cur[(j > 0) ? j - 1 : 0];
						end
					end
				end
			end
			CMD_REMOVE: begin
				if (!dup) st1 = STS_NOTFOUND;
				else begin
					wr_ok = 1'b1;
					n_new = n_sel - CNT_W'(1);
					for (int j = 0; j < SET_DEPTH - 1; j++) begin
						if (ge[j] && (CNT_W'(j + 1) < n_sel)) begin
							nxt[j] = cur[j+1];
						end
					end
				end
			end
			default: st1 = STS_OK;
		endcase
	end

	// membership of the current scan element in the other set
	always_comb begin
		if (state_q == S_UNI || x_is_b_q) xv = b_q[i_q[IDX_W-1:0]];
		else xv = a_q[i_q[IDX_W-1:0]];
		n_x  = (state_q == S_UNI || x_is_b_q) ? cnt_b_q : cnt_a_q;
		n_y  = x_is_b_q ? cnt_a_q : cnt_b_q;
		in_y = 1'b0;
		for (int j = 0; j < SET_DEPTH; j++) begin
			if (CNT_W'(j) < n_y && (x_is_b_q ? a_q[j] : b_q[j]) == xv) in_y = 1'b1;
		end
		scan_end = (i_q >= n_x);
		cand     = (state_q == S_UNI) ? 1'b1 : (in_y == want_q);
	end

	always_comb begin
		pop       = 1'b0;
		emit      = 1'b0;
		o         = '0;
		o.size_a  = SZ_W'(cnt_a_q);
		o.size_b  = SZ_W'(cnt_b_q);
		o.out_value = pend_q;
		case (state_q)
			S_IDLE: begin
				if (stat.valid && ofree) begin
					pop = 1'b1;
					if (!head.is_scan) begin
						emit        = 1'b1;
						o.out_value = '0;
						o.out_last  = 1'b1;
						o.status    = st1;
						if (wr_ok && !head.item.set_sel) o.size_a = SZ_W'(n_new);
						if (wr_ok && head.item.set_sel) o.size_b = SZ_W'(n_new);
					end
				end
			end
			S_SCAN, S_UNI: begin
				emit = ofree && !scan_end && cand && !subop_q && pend_v_q;
			end
			S_FIN: begin
				emit = ofree;
				o.out_last = 1'b1;
				if (subop_q) begin
					o.out_value = '0;
					o.is_subset = sub_q;
				end else if (!pend_v_q) begin
					o.out_value = '0;
					o.status    = STS_EMPTY;
				end
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_a_q  <= '0;
			cnt_b_q  <= '0;
			ov_q     <= 1'b0;
			pend_v_q <= 1'b0;
			i_q      <= '0;
			x_is_b_q <= 1'b0;
			want_q   <= 1'b0;
			uni_q    <= 1'b0;
			subop_q  <= 1'b0;
			sub_q    <= 1'b0;
		end else begin
			if (ofree) ov_q <= emit;
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						if (wr_ok && !head.item.set_sel) cnt_a_q <= n_new;
						if (wr_ok && head.item.set_sel) cnt_b_q <= n_new;
						if (head.is_scan) begin
							state_q  <= S_SCAN;
							i_q      <= '0;
							x_is_b_q <= head.x_is_b;
							want_q   <= head.want;
							uni_q    <= head.union_tail;
							subop_q  <= head.subset_op;
							sub_q    <= 1'b1;
							pend_v_q <= 1'b0;
						end
					end
				end
				S_SCAN: begin
					if (ofree) begin
						if (scan_end) begin
							i_q     <= '0;
							state_q <= uni_q ? S_UNI : S_FIN;
						end else begin
							i_q <= i_q + CNT_W'(1);
							if (cand && subop_q) sub_q <= 1'b0;
							if (cand && !subop_q) pend_v_q <= 1'b1;
						end
					end
				end
				S_UNI: begin
					if (ofree) begin
						if (scan_end) begin
							state_q <= S_FIN;
						end else begin
							i_q      <= i_q + CNT_W'(1);
							pend_v_q <= 1'b1;
						end
					end
				end
				S_FIN: begin
					if (ofree) begin
						state_q  <= S_IDLE;
						pend_v_q <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ofree && emit) out_q <= o;
		if ((state_q == S_SCAN || state_q == S_UNI) && ofree && !scan_end && cand && !subop_q) begin
			pend_q <= xv;
		end
		if (pop && wr_ok) begin
			for (int j = 0; j < SET_DEPTH; j++) begin
				if (head.item.set_sel) b_q[j] <= nxt[j];
				else a_q[j] <= nxt[j];
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_a_q <= CNT_W'(SET_DEPTH)) && (cnt_b_q <= CNT_W'(SET_DEPTH)))
		else $error("set count above capacity");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == S_IDLE))
		else $error("queue popped while a run is in progress");

	a_no_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_v_q)
		else $error("pending element left over after a run");

	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |=> ($stable(cnt_a_q) && $stable(cnt_b_q)))
		else $error("set count changed during a run");

endmodule

@@ src/two_set_store_with_set_operations.sv @@
// two_set_store_with_set_operations: top level of the two-set store
// depends on tsso_pkg, tsso_front, tsso_queue, tsso_back

// Holds two ordered sets A and B of up to SET_DEPTH distinct signed words and
// runs one command per item: insert at a position, remove a value, intersect,
// union, A minus B, B minus A, subset test and size report. Insert, remove and
// size are done as the back end takes the item and give one result item. Set
// operations and the subset test take the item, then scan one element of the
// scanned set per cycle while the output is not stalled, testing it against the
// other set with a parallel compare, giving one result item per element found,
// the last one marked as last (subset test: a single item); a run with
// nothing in it gives a single item with status empty. The front stage and a
// two-entry queue take new items while the back end is still scanning or its
// output is stalled.

module two_set_store_with_set_operations (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  tsso_pkg::cmd_item_t cmd_item,
	output logic                res_valid,
	input  logic                res_stall,
	output tsso_pkg::res_item_t res_item
);
	import tsso_pkg::*;

	// front to queue
	logic      push;
	cls_item_t push_item;
	// queue to back
	cls_item_t head;
	q_stat_t   stat;
	logic      pop;

	tsso_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_item  (cmd_item),
		.push      (push),
		.push_item (push_item),
		.q_full    (stat.full)
	);

	tsso_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.stat      (stat)
	);

	tsso_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (stat),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

endmodule

@@ tb/two_set_store_with_set_operations_test.sv @@
// two_set_store_with_set_operations_test: self-checking bench for the two-set store
// depends on tsso_pkg and two_set_store_with_set_operations

module two_set_store_with_set_operations_test;
	import tsso_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	cmd_item_t cmd_item;
	logic      res_valid;
	logic      res_stall;
	res_item_t res_item;

	two_set_store_with_set_operations u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_item  (cmd_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	// predicted contents of both sets
	logic signed [31:0] set_a [SET_DEPTH];
	logic signed [31:0] set_b [SET_DEPTH];
	int                 cnt_a;
	int                 cnt_b;

	cmd_item_t pending_cmds[$];
	res_item_t expected_res[$];
	int        errors;
	bit        stim_done;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic bit set_has(bit in_b, logic signed [31:0] v);
		int n;
		n = in_b ? cnt_b : cnt_a;
		for (int i = 0; i < n; i++)
			if ((in_b ? set_b[i] : set_a[i]) == v)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic res_item_t make_res(logic signed [31:0] v, logic lst,
	                                       logic [2:0] st, logic sub);
		res_item_t r;
		r.out_value = v;
		r.out_last  = lst;
		r.status    = st;
		r.is_subset = sub;
		r.size_a    = cnt_a[SZ_W-1:0];
		r.size_b    = cnt_b[SZ_W-1:0];
		return r;
	endfunction

	// updates the predicted sets and queues the results one command causes
	task automatic predict_cmd(cmd_item_t c);
		res_item_t          run[$];
		logic [2:0]         st;
		logic               sub;
		int                 idx;
		logic signed [31:0] tmp [SET_DEPTH];
		int                 n;
		st  = STS_OK;
		sub = 1'b0;
		case (c.cmd)
			CMD_INSERT: begin
				n = c.set_sel ? cnt_b : cnt_a;
				if (c.set_sel)
					tmp = set_b;
				else
					tmp = set_a;
				if (set_has(c.set_sel, c.elem_value))
					st = STS_DUP;
				else if (int'(c.insert_pos) > n)
					st = STS_BADPOS;
				else if (n >= SET_DEPTH)
					st = STS_FULL;
				else begin
					for (int i = n; i > int'(c.insert_pos); i--)
						tmp[i] = tmp[i-1];
					tmp[c.insert_pos] = c.elem_value;
					if (c.set_sel) begin
						set_b = tmp;
						cnt_b++;
					end else begin
						set_a = tmp;
						cnt_a++;
					end
				end
				expected_res.push_back(make_res(0, 1'b1, st, 1'b0));
			end
			CMD_REMOVE: begin
				n = c.set_sel ? cnt_b : cnt_a;
				if (c.set_sel)
					tmp = set_b;
				else
					tmp = set_a;
				idx = -1;
				for (int i = 0; i < n; i++)
					if (idx < 0 && tmp[i] == c.elem_value)
						idx = i;
				if (idx < 0)
					st = STS_NOTFOUND;
				else begin
					for (int i = idx; i + 1 < n; i++)
						tmp[i] = tmp[i+1];
					if (c.set_sel) begin
						set_b = tmp;
						cnt_b--;
					end else begin
						set_a = tmp;
						cnt_a--;
					end
				end
				expected_res.push_back(make_res(0, 1'b1, st, 1'b0));
			end
			CMD_SUBSET: begin
				sub = 1'b1;
				for (int i = 0; i < cnt_b; i++)
					if (!set_has(1'b0, set_b[i]))
						sub = 1'b0;
				expected_res.push_back(make_res(0, 1'b1, STS_OK, sub));
			end
			CMD_SIZE:
				expected_res.push_back(make_res(0, 1'b1, STS_OK, 1'b0));
			default: begin
				if (c.cmd == CMD_B_MINUS_A) begin
					for (int i = 0; i < cnt_b; i++)
						if (!set_has(1'b0, set_b[i]))
							run.push_back(make_res(set_b[i], 1'b0, STS_OK, 1'b0));
				end else begin
					// intersect keeps A's elements found in B, the others keep the absent ones
					for (int i = 0; i < cnt_a; i++)
						if (set_has(1'b1, set_a[i]) == (c.cmd == CMD_INTERSECT))
							run.push_back(make_res(set_a[i], 1'b0, STS_OK, 1'b0));
					if (c.cmd == CMD_UNION)
						for (int i = 0; i < cnt_b; i++)
							run.push_back(make_res(set_b[i], 1'b0, STS_OK, 1'b0));
				end
				if (run.size() == 0)
					run.push_back(make_res(0, 1'b1, STS_EMPTY, 1'b0));
				run[run.size()-1].out_last = 1'b1;
				foreach (run[i])
					expected_res.push_back(run[i]);
			end
		endcase
	endtask

	function automatic cmd_item_t mk_cmd(logic [2:0] op, logic sel,
	                                     logic signed [31:0] v, logic [4:0] pos);
		cmd_item_t c;
		c.cmd        = op;
		c.set_sel    = sel;
		c.elem_value = v;
		c.insert_pos = pos;
		return c;
	endfunction

	// values drawn from a small pool so duplicates and hits are common
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 3))
			0:       return $urandom;
			1:       return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom_range(0, 23)) - 12;
		endcase
	endfunction

	// stimulus: directed part first, then random items
	initial begin
		int       na;
		int       nb;
		cmd_item_t c;
		errors = 0;
		stim_done = 1'b0;
		cnt_a = 0;
		cnt_b = 0;
		// empty sets: every run is empty, subset of empty B is true
		pending_cmds.push_back(mk_cmd(CMD_INTERSECT, 0, 0, 0));
		pending_cmds.push_back(mk_cmd(CMD_UNION, 0, 0, 0));
		pending_cmds.push_back(mk_cmd(CMD_SUBSET, 0, 0, 0));
		pending_cmds.push_back(mk_cmd(CMD_REMOVE, 1, 5, 0));
		pending_cmds.push_back(mk_cmd(CMD_INSERT, 0, 32'sh7fffffff, 0));
		pending_cmds.push_back(mk_cmd(CMD_INSERT, 0, 32'sh80000000, 1));
		pending_cmds.push_back(mk_cmd(CMD_INSERT, 0, 32'sh80000000, 0));  // duplicate
		pending_cmds.push_back(mk_cmd(CMD_INSERT, 0, 9, 5'd31));          // bad position
		pending_cmds.push_back(mk_cmd(CMD_INSERT, 1, 32'sh7fffffff, 0));
		pending_cmds.push_back(mk_cmd(CMD_INSERT, 1, -1, 0));
		pending_cmds.push_back(mk_cmd(CMD_SUBSET, 0, 0, 0));
		pending_cmds.push_back(mk_cmd(CMD_INTERSECT, 0, 0, 0));
		pending_cmds.push_back(mk_cmd(CMD_UNION, 0, 0, 0));
		pending_cmds.push_back(mk_cmd(CMD_A_MINUS_B, 0, 0, 0));
		pending_cmds.push_back(mk_cmd(CMD_B_MINUS_A, 0, 0, 0));
		pending_cmds.push_back(mk_cmd(CMD_SIZE, 1, 32'shffffffff, 5'd31));
		pending_cmds.push_back(mk_cmd(CMD_REMOVE, 1, -1, 0));
		pending_cmds.push_back(mk_cmd(CMD_SUBSET, 0, 0, 0));
		// fill A to capacity, then overflow it
		for (int i = 0; i < 15; i++)
			pending_cmds.push_back(mk_cmd(CMD_INSERT, 0, 100 + i, 5'(2 + i)));
		pending_cmds.push_back(mk_cmd(CMD_INSERT, 0, 555, 5'd16));
		pending_cmds.push_back(mk_cmd(CMD_INSERT, 0, 556, 5'd0));
		pending_cmds.push_back(mk_cmd(CMD_UNION, 0, 0, 0));
		// random part, positions tracked loosely so most inserts land
		na = SET_DEPTH;
		nb = 1;
		for (int i = 0; i < 122; i++) begin
			c.cmd        = 3'($urandom_range(0, 7));
			if ($urandom_range(0, 2) != 0)
				c.cmd = $urandom_range(0, 1) ? CMD_INSERT : CMD_REMOVE;
			c.set_sel    = 1'($urandom_range(0, 1));
			c.elem_value = pick_value();
			if ($urandom_range(0, 9) == 0)
				c.insert_pos = 5'($urandom);
			else
				c.insert_pos = 5'($urandom_range(0, c.set_sel ? nb : na));
			if (c.cmd == CMD_INSERT) begin
				if (c.set_sel && nb < SET_DEPTH) nb++;
				if (!c.set_sel && na < SET_DEPTH) na++;
			end else if (c.cmd == CMD_REMOVE && $urandom_range(0, 1)) begin
				if (c.set_sel && nb > 0) nb--;
				if (!c.set_sel && na > 0) na--;
			end
			pending_cmds.push_back(c);
		end
		pending_cmds.push_back(mk_cmd(CMD_UNION, 0, 0, 0));
		pending_cmds.push_back(mk_cmd(CMD_SIZE, 0, 0, 0));
	end

	// reset, then release it
	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver: bursts of random length with random gaps
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid  <= 1'b0;
			cmd_item   <= '0;
			burst_left <= 0;
			gap_left   <= 0;
		end else begin
			// the item on the bus went in at this edge
			if (cmd_valid && !cmd_stall)
				predict_cmd(cmd_item);
			if (!cmd_valid || !cmd_stall) begin
				if (gap_left > 0) begin
					gap_left  <= gap_left - 1;
					cmd_valid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					cmd_item  <= pending_cmds.pop_front();
					cmd_valid <= 1'b1;
					if (burst_left > 0)
						burst_left <= burst_left - 1;
					else begin
						burst_left <= $urandom_range(0, 12);
						gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					cmd_valid <= 1'b0;
					stim_done <= 1'b1;
				end
			end
		end
	end

	// receiver stall pattern, with one long hold-off counted here
	int rx_cycle;
	int hold_cnt;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			rx_cycle  <= 0;
			hold_cnt  <= 0;
		end else begin
			rx_cycle <= rx_cycle + 1;
			if (rx_cycle == 300)
				hold_cnt <= 400;
			if (hold_cnt > 0) begin
				hold_cnt  <= hold_cnt - 1;
				res_stall <= 1'b1;
			end else if ((rx_cycle / 200) % 3 == 2)
				res_stall <= 1'b0;  // stretches with no stall
			else
				res_stall <= ($urandom_range(0, 3) == 0);
		end
	end

	// monitor: compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		res_item_t e;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_res.size() == 0) begin
				$display("%0t: unexpected result %p", $time, res_item);
				errors++;
			end else begin
				e = expected_res.pop_front();
				if (res_item !== e) begin
					$display("%0t: mismatch expected %p actual %p", $time, e, res_item);
					errors++;
				end
			end
		end
	end

	// end of run: drained, then a short settle
	initial begin
		@(posedge arst_n);
		wait (stim_done && expected_res.size() == 0);
		repeat (80) @(posedge clk);
		if (errors == 0 && expected_res.size() == 0)
			$display("two_set_store_with_set_operations_test passed");
		else
			$display("two_set_store_with_set_operations_test failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("two_set_store_with_set_operations_test failed");
		$finish;
	end

endmodule
